[rtl/rsd_pkg.sv]
// ============================================================================
// rsd_pkg: shared types and constants of the ROM image stream deframer
// Section and status codes, header layout constants and the stage payloads.
// ============================================================================
package rsd_pkg;

    localparam int OFFSET_W = 22;
    localparam int SIZE_W   = OFFSET_W + 1;

    // Section / phase codes
    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_TRAINER   = 3'd1;
    localparam logic [2:0] PH_PROGRAM   = 3'd2;
    localparam logic [2:0] PH_CHARACTER = 3'd3;
    localparam logic [2:0] PH_INST      = 3'd4;
    localparam logic [2:0] PH_PROM      = 3'd5;
    localparam logic [2:0] PH_TITLE     = 3'd6;
    localparam logic [2:0] PH_DISCARD   = 3'd7;

    // Status codes
    localparam logic [3:0] ST_RUNNING     = 4'd0;
    localparam logic [3:0] ST_DONE        = 4'd1;
    localparam logic [3:0] ST_SHORT_HDR   = 4'd2;
    localparam logic [3:0] ST_BAD_MAGIC   = 4'd3;
    localparam logic [3:0] ST_BAD_PADDING = 4'd4;
    localparam logic [3:0] ST_SHORT_BASE  = 4'd4;  // short code = phase + base

    // Section sizes and header layout
    localparam logic [SIZE_W-1:0]   HEADER_SIZE  = SIZE_W'(16);
    localparam logic [SIZE_W-1:0]   TRAINER_SIZE = SIZE_W'(512);
    localparam logic [SIZE_W-1:0]   INST_SIZE    = SIZE_W'(8192);
    localparam logic [SIZE_W-1:0]   PROM_SIZE    = SIZE_W'(32);
    localparam logic [SIZE_W-1:0]   TITLE_MAX    = SIZE_W'(127);
    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = {OFFSET_W{1'b1}};

    localparam logic [OFFSET_W-1:0] HDR_PRG_POS  = OFFSET_W'(4);
    localparam logic [OFFSET_W-1:0] HDR_CHR_POS  = OFFSET_W'(5);
    localparam logic [OFFSET_W-1:0] HDR_FLG6_POS = OFFSET_W'(6);
    localparam logic [OFFSET_W-1:0] HDR_FLG7_POS = OFFSET_W'(7);
    localparam logic [OFFSET_W-1:0] HDR_PAD_POS  = OFFSET_W'(11);
    localparam logic [OFFSET_W-1:0] MAGIC_LEN    = OFFSET_W'(4);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [2:0]          section;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          byte_out;
        logic [3:0]          status;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    magic_byte = 8'h4E;
            2'd1:    magic_byte = 8'h45;
            2'd2:    magic_byte = 8'h53;
            default: magic_byte = 8'h1A;
        endcase
    endfunction

endpackage

[rtl/rom_image_stream_deframer.sv]
// ============================================================================
// rom_image_stream_deframer: cartridge image byte tagger
// Splits a byte stream into header, trainer, program, character, instruction
// ROM, PROM, title and discard sections, with offsets and file status.
// ============================================================================
// Each byte passes through the input register, then the result register.
// Throughput: 1 byte per cycle unless i_out_stall holds the result; the state
// update is one pass of counter and compare logic between the two registers.
// Reset: synchronous, active low; clears the file state, the padding-check
// register and both stage valids. No clearing pass is needed.
module rom_image_stream_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_section,
    output logic [21:0] o_offset,
    output logic [7:0]  o_byte_out,
    output logic [3:0]  o_status
);
    import rsd_pkg::*;

    t_item   w_in_item;
    t_item   w_held_item;
    t_result w_core_result;
    t_result w_out_result;
    logic    w_held_valid;
    logic    w_out_ready;
    logic    w_advance;

    assign w_in_item.data_byte = i_data_byte;
    assign w_in_item.last_byte = i_last_byte;

    // Advance the held transaction whenever the result register has room;
    // the core state updates in the same edge.
    assign w_advance = w_held_valid && w_out_ready;

    rsd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (w_in_item),
        .i_advance  (w_advance),
        .o_valid    (w_held_valid),
        .o_item     (w_held_item)
    );

    rsd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (w_advance),
        .i_item        (w_held_item),
        .o_result      (w_core_result)
    );

    // Result register parts the two sides: a stalled result blocks the input
    // register from taking the next byte only while it already holds one.
    rsd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_held_valid),
        .i_result    (w_core_result),
        .o_ready     (w_out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_out_result)
    );

    assign o_section  = w_out_result.section;
    assign o_offset   = w_out_result.offset;
    assign o_byte_out = w_out_result.byte_out;
    assign o_status   = w_out_result.status;

    // Input side stalls only when both stages are full and downstream holds
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && w_held_valid))
        else $error("input stalled without a full pipeline");

    a_magic_sect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BAD_MAGIC)
            |-> (o_section == PH_HEADER || o_section == PH_DISCARD))
        else $error("bad magic reported outside header or discard");

    a_title_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_section == PH_TITLE)
            |-> ({1'b0, o_offset} < TITLE_MAX))
        else $error("title offset beyond title length");

endmodule

[rtl/rsd_in_stage.sv]
// ============================================================================
// rsd_in_stage: input register
// Captures one byte transaction and holds it until the core advances it.
// ============================================================================
module rsd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rsd_pkg::t_item i_item,
    input  logic          i_advance,
    output logic          o_valid,
    output rsd_pkg::t_item o_item
);
    import rsd_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // Room when empty or when the held transaction leaves this cycle
    assign o_in_stall = r_valid && !i_advance;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/rsd_core.sv]
// ============================================================================
// rsd_core: deframing state and tagging logic
// Tracks section and offset, checks the header and forms one result per byte.
// ============================================================================
module rsd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_advance,
    input  rsd_pkg::t_item  i_item,
    output rsd_pkg::t_result o_result
);
    import rsd_pkg::*;

    logic                r_enforce;
    logic [2:0]          r_phase,   n_phase;
    logic [OFFSET_W-1:0] r_off,     n_off;
    logic [7:0]          r_prg,     n_prg;
    logic [7:0]          r_chr,     n_chr;
    logic                r_trn,     n_trn;
    logic                r_arc,     n_arc;
    logic                r_mm,      n_mm;
    logic                r_pad,     n_pad;
    logic [3:0]          r_err,     n_err;

    logic [SIZE_W-1:0]   w_off_inc;
    logic [SIZE_W-1:0]   w_size;
    logic                w_complete;
    logic [5:0]          w_present;
    logic [2:0]          w_next;
    logic [3:0]          w_status;

    function automatic logic [2:0] next_required(input logic [2:0] p,
                                                 input logic [5:0] present);
        logic       found;
        logic [2:0] q;
        found = 1'b0;
        next_required = PH_TITLE;
        for (int k = 1; k <= 5; k++) begin
            q = 3'(k);
            if (!found && q > p && present[k]) begin
                found = 1'b1;
                next_required = q;
            end
        end
    endfunction

    function automatic logic [3:0] short_code(input logic [2:0] p);
        short_code = (p == PH_HEADER) ? ST_SHORT_HDR : ST_SHORT_BASE + 4'(p);
    endfunction

    always_comb begin
        case (r_phase)
            PH_HEADER:    w_size = HEADER_SIZE;
            PH_TRAINER:   w_size = r_trn ? TRAINER_SIZE : '0;
            PH_PROGRAM:   w_size = {1'b0, r_prg, 14'b0};
            PH_CHARACTER: w_size = {2'b0, r_chr, 13'b0};
            PH_INST:      w_size = r_arc ? INST_SIZE : '0;
            PH_PROM:      w_size = r_arc ? PROM_SIZE : '0;
            default:      w_size = '0;
        endcase
    end

    assign w_off_inc  = {1'b0, r_off} + SIZE_W'(1);
    assign w_complete = w_off_inc >= w_size;
    assign w_present  = {r_arc, r_arc, (r_chr != 8'd0), (r_prg != 8'd0), r_trn, 1'b1};
    assign w_next     = next_required(r_phase, w_present);

    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_prg    = r_prg;
        n_chr    = r_chr;
        n_trn    = r_trn;
        n_arc    = r_arc;
        n_mm     = r_mm;
        n_pad    = r_pad;
        n_err    = r_err;
        w_status = ST_RUNNING;

        if (r_phase <= PH_PROM) begin
            if (r_phase == PH_HEADER) begin
                if (r_off < MAGIC_LEN && i_item.data_byte != magic_byte(r_off[1:0])) begin
                    n_mm = 1'b1;
                end
                if (r_off == HDR_PRG_POS)  n_prg = i_item.data_byte;
                if (r_off == HDR_CHR_POS)  n_chr = i_item.data_byte;
                if (r_off == HDR_FLG6_POS) n_trn = i_item.data_byte[2];
                if (r_off == HDR_FLG7_POS) n_arc = i_item.data_byte[1];
                if (r_off >= HDR_PAD_POS && i_item.data_byte != 8'd0) begin
                    n_pad = 1'b1;
                end
                if (w_complete) begin
                    if (n_mm) begin
                        n_err = ST_BAD_MAGIC;
                    end else if (r_enforce && n_pad) begin
                        n_err = ST_BAD_PADDING;
                    end
                end
            end
            if (n_err != ST_RUNNING) begin
                w_status = n_err;
                n_phase  = PH_DISCARD;
                n_off    = '0;
            end else if (w_complete) begin
                if (i_item.last_byte) begin
                    w_status = (w_next <= PH_PROM) ? short_code(w_next) : ST_DONE;
                end
                n_phase = w_next;
                n_off   = '0;
            end else begin
                if (i_item.last_byte) begin
                    w_status = short_code(r_phase);
                end
                n_off = w_off_inc[OFFSET_W-1:0];
            end
        end else if (r_phase == PH_TITLE) begin
            if (i_item.last_byte) begin
                w_status = ST_DONE;
            end
            if (w_off_inc >= TITLE_MAX) begin
                n_phase = PH_DISCARD;
                n_off   = '0;
            end else begin
                n_off = w_off_inc[OFFSET_W-1:0];
            end
        end else begin
            if (r_err != ST_RUNNING) begin
                w_status = r_err;
            end else if (i_item.last_byte) begin
                w_status = ST_DONE;
            end
            if (r_off != OFFSET_MAX) begin
                n_off = w_off_inc[OFFSET_W-1:0];
            end
        end

        // Final byte: drop all file state, next byte opens a new header
        if (i_item.last_byte) begin
            n_phase = PH_HEADER;
            n_off   = '0;
            n_prg   = '0;
            n_chr   = '0;
            n_trn   = 1'b0;
            n_arc   = 1'b0;
            n_mm    = 1'b0;
            n_pad   = 1'b0;
            n_err   = ST_RUNNING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enforce <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_enforce <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off   <= '0;
            r_prg   <= '0;
            r_chr   <= '0;
            r_trn   <= 1'b0;
            r_arc   <= 1'b0;
            r_mm    <= 1'b0;
            r_pad   <= 1'b0;
            r_err   <= ST_RUNNING;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_prg   <= n_prg;
            r_chr   <= n_chr;
            r_trn   <= n_trn;
            r_arc   <= n_arc;
            r_mm    <= n_mm;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

    assign o_result.section  = r_phase;
    assign o_result.offset   = r_off;
    assign o_result.byte_out = i_item.data_byte;
    assign o_result.status   = w_status;

    a_err_discard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_RUNNING) |-> (r_phase == PH_DISCARD))
        else $error("latched error outside discard phase");

    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_off < HEADER_SIZE[OFFSET_W-1:0]))
        else $error("header offset past header end");

endmodule

[rtl/rsd_out_stage.sv]
// ============================================================================
// rsd_out_stage: result register
// Holds one tagged byte until the downstream side takes it.
// ============================================================================
module rsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rsd_pkg::t_result i_result,
    output logic             o_ready,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output rsd_pkg::t_result o_result
);
    import rsd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
